[hw/rtl/ptb_pkg.sv]
`default_nettype none
package ptb_pkg;

	localparam int NUM_TIMERS_DEF = 8;

	localparam int CMD_W  = 2;
	localparam int IDX_W  = 3;
	localparam int DUR_W  = 32;
	localparam int STAT_W = 2;
	localparam int MASK_W = 8;
	localparam int CNT32_W = 32;
	localparam int MICRO_W = 20;

	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd1;
	localparam logic [CMD_W-1:0] CMD_POLL     = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNREG = 2'd2;

	localparam logic [MICRO_W-1:0] MICROS_PER_SECOND = 20'd1000000;
	localparam logic [MICRO_W-1:0] MPT_RESET         = 20'd1000;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_REGISTER,
		OP_POLL,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [DUR_W-1:0] dur;
	} qent_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_OUT  = 3'b100
	} bstate_t;

endpackage
`default_nettype wire

[hw/rtl/ptb_if.sv]
`default_nettype none
interface ptb_in_if;
	logic                       valid;
	logic                       ready;
	logic [ptb_pkg::CMD_W-1:0]  command;
	logic [ptb_pkg::IDX_W-1:0]  timer_index;
	logic [ptb_pkg::DUR_W-1:0]  duration_ticks;

	modport source (output valid, command, timer_index, duration_ticks, input ready);
	modport sink (input valid, command, timer_index, duration_ticks, output ready);
endinterface

interface ptb_out_if;
	logic                         valid;
	logic                         ready;
	logic [ptb_pkg::STAT_W-1:0]   status;
	logic [ptb_pkg::IDX_W-1:0]    assigned_index;
	logic                         elapsed;
	logic [ptb_pkg::MASK_W-1:0]   fire_mask;
	logic [ptb_pkg::CNT32_W-1:0]  tick_count;
	logic [ptb_pkg::CNT32_W-1:0]  seconds_count;
	logic [ptb_pkg::MICRO_W-1:0]  sub_second_micros;

	modport source (output valid, status, assigned_index, elapsed, fire_mask, tick_count,
		seconds_count, sub_second_micros, input ready);
	modport sink (input valid, status, assigned_index, elapsed, fire_mask, tick_count,
		seconds_count, sub_second_micros, output ready);
endinterface

interface ptb_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [ptb_pkg::MICRO_W-1:0]  data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/periodic_timer_bank_unit.sv]
// an item leaves the queue in idle; a tick with timers in use then scans the timer ram
//   one entry a cycle, and every item ends in the output state, which waits for a free
//   result register; the back end takes no new item until it is back in idle
// a two-entry queue lets input transfers continue while the back end is busy
// reset (arst_n low): counters, timer count, elapsed flags and queue cleared,
//   micros_per_tick back to 1000; timer ram contents are not cleared
`default_nettype none
module periodic_timer_bank_unit #(
	parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ptb_in_if.sink    in_ch,
	ptb_out_if.source out_ch,
	ptb_cfg_if.sink   cfg_ch
);
	logic [ptb_pkg::MICRO_W-1:0] mpt_q;
	logic                        q_valid;
	logic                        q_pop;
	ptb_pkg::qent_t              q_entry;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mpt_q <= ptb_pkg::MPT_RESET;
		else if (cfg_ch.valid)
			mpt_q <= cfg_ch.data;
	end

	ptb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_entry (q_entry)
	);

	ptb_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.micros_per_tick (mpt_q),
		.q_valid         (q_valid),
		.q_pop           (q_pop),
		.q_entry         (q_entry),
		.out_ch          (out_ch)
	);
endmodule
`default_nettype wire

[hw/rtl/ptb_ram.sv]
`default_nettype none
module ptb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/ptb_front.sv]
`default_nettype none
module ptb_front (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ptb_in_if.sink      in_ch,
	output logic        q_valid,
	input  wire logic   q_pop,
	output ptb_pkg::qent_t q_entry
);
	ptb_pkg::qent_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	ptb_pkg::qent_t cls;
	logic           push;
	logic           pop;

	// decode the command into an operation for the back end
	always_comb begin
		cls.idx = in_ch.timer_index;
		cls.dur = in_ch.duration_ticks;
		case (in_ch.command)
			ptb_pkg::CMD_TICK:     cls.op = ptb_pkg::OP_TICK;
			ptb_pkg::CMD_REGISTER: cls.op = ptb_pkg::OP_REGISTER;
			ptb_pkg::CMD_POLL:     cls.op = ptb_pkg::OP_POLL;
			default:               cls.op = ptb_pkg::OP_NOP;
		endcase
	end

	assign in_ch.ready = (count_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (count_q != 2'd0);
	assign pop         = q_pop && q_valid;
	assign q_entry     = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

[hw/rtl/ptb_back.sv]
`default_nettype none
module ptb_back #(
	parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [ptb_pkg::MICRO_W-1:0]   micros_per_tick,
	input  wire logic                          q_valid,
	output logic                               q_pop,
	input  wire ptb_pkg::qent_t                q_entry,
	ptb_out_if.source                          out_ch
);
	localparam int TIDX_W = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
	localparam int CMP_W  = CNT_W > ptb_pkg::IDX_W ? CNT_W : ptb_pkg::IDX_W;
	localparam int DW     = ptb_pkg::DUR_W;
	localparam int WORD_W = 2 * DW;
	localparam int SUM_W  = ptb_pkg::MICRO_W + 1;
	localparam logic [SUM_W-1:0] MPS = {1'b0, ptb_pkg::MICROS_PER_SECOND};

	ptb_pkg::bstate_t state_q;
	logic [ptb_pkg::CNT32_W-1:0] ticks_q;
	logic [ptb_pkg::CNT32_W-1:0] seconds_q;
	logic [ptb_pkg::MICRO_W-1:0] rem_q;
	logic [CNT_W-1:0]            in_use_q;
	logic [NUM_TIMERS-1:0]       flags_q;
	logic [TIDX_W-1:0]           cnt_q;

	logic [ptb_pkg::STAT_W-1:0]  status_q;
	logic [ptb_pkg::IDX_W-1:0]   assigned_q;
	logic                        elapsed_q;
	logic [ptb_pkg::MASK_W-1:0]  mask_q;

	logic                        out_valid_q;
	logic [ptb_pkg::STAT_W-1:0]  o_status_q;
	logic [ptb_pkg::IDX_W-1:0]   o_assigned_q;
	logic                        o_elapsed_q;
	logic [ptb_pkg::MASK_W-1:0]  o_mask_q;
	logic [ptb_pkg::CNT32_W-1:0] o_ticks_q;
	logic [ptb_pkg::CNT32_W-1:0] o_seconds_q;
	logic [ptb_pkg::MICRO_W-1:0] o_rem_q;

	logic                 ram_we;
	logic [TIDX_W-1:0]    ram_waddr;
	logic [WORD_W-1:0]    ram_wdata;
	logic                 ram_re;
	logic [TIDX_W-1:0]    ram_raddr;
	logic [WORD_W-1:0]    ram_rdata;

	logic [SUM_W-1:0]     sum0;
	logic [SUM_W-1:0]     sum1;
	logic [SUM_W-1:0]     sum2;
	logic                 c1;
	logic                 c2;
	logic [DW-1:0]        rd_end;
	logic [DW-1:0]        rd_period;
	logic                 fire;
	logic                 last;
	logic                 table_full;
	logic                 poll_bad;
	logic [TIDX_W-1:0]    slot;
	logic [TIDX_W-1:0]    pidx;
	logic                 out_free;
	logic                 start;

	ptb_ram #(.WIDTH(WORD_W), .DEPTH(NUM_TIMERS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sub-second carry, at most two seconds per tick
	always_comb begin
		sum0 = {1'b0, rem_q} + {1'b0, micros_per_tick};
		c1   = sum0 >= MPS;
		sum1 = c1 ? sum0 - MPS : sum0;
		c2   = sum1 >= MPS;
		sum2 = c2 ? sum1 - MPS : sum1;
	end

	assign rd_end     = ram_rdata[WORD_W-1:DW];
	assign rd_period  = ram_rdata[DW-1:0];
	assign fire       = ticks_q >= rd_end;
	assign last       = (CNT_W'(cnt_q) + CNT_W'(1)) == in_use_q;
	assign table_full = in_use_q >= CNT_W'(NUM_TIMERS);
	assign poll_bad   = CMP_W'(q_entry.idx) >= CMP_W'(in_use_q);
	assign slot       = TIDX_W'(in_use_q);
	assign pidx       = TIDX_W'(q_entry.idx);
	assign out_free   = !out_valid_q || out_ch.ready;
	assign start      = (state_q == ptb_pkg::S_IDLE) && q_valid;
	assign q_pop      = start;

	// scan reads entry cnt+1, rewrites cnt if it fired
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = {rd_end + rd_period, rd_period};
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (start && q_entry.op == ptb_pkg::OP_REGISTER && !table_full) begin
			ram_we    = 1'b1;
			ram_waddr = slot;
			ram_wdata = {ticks_q + q_entry.dur, q_entry.dur};
		end else if (start && q_entry.op == ptb_pkg::OP_TICK) begin
			ram_re = 1'b1;
		end else if (state_q == ptb_pkg::S_SCAN) begin
			ram_we    = fire;
			ram_re    = !last;
			ram_raddr = cnt_q + TIDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptb_pkg::S_IDLE;
			ticks_q     <= '0;
			seconds_q   <= '0;
			rem_q       <= '0;
			in_use_q    <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ptb_pkg::S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ptb_pkg::S_IDLE: begin
					if (q_valid) begin
						case (q_entry.op)
							ptb_pkg::OP_TICK: begin
								ticks_q   <= ticks_q + ptb_pkg::CNT32_W'(1);
								rem_q     <= sum2[ptb_pkg::MICRO_W-1:0];
								seconds_q <= seconds_q + {30'd0, {1'b0, c1} + {1'b0, c2}};
								state_q   <= (in_use_q == '0) ? ptb_pkg::S_OUT
									: ptb_pkg::S_SCAN;
							end
							ptb_pkg::OP_REGISTER: begin
								if (!table_full) begin
									flags_q[slot] <= 1'b0;
									in_use_q      <= in_use_q + CNT_W'(1);
								end
								state_q <= ptb_pkg::S_OUT;
							end
							ptb_pkg::OP_POLL: begin
								if (!poll_bad)
									flags_q[pidx] <= 1'b0;
								state_q <= ptb_pkg::S_OUT;
							end
							default: state_q <= ptb_pkg::S_OUT;
						endcase
					end
				end
				ptb_pkg::S_SCAN: begin
					if (fire)
						flags_q[cnt_q] <= 1'b1;
					if (last)
						state_q <= ptb_pkg::S_OUT;
				end
				ptb_pkg::S_OUT: begin
					if (out_free)
						state_q <= ptb_pkg::S_IDLE;
				end
				default: state_q <= ptb_pkg::S_IDLE;
			endcase
		end
	end

	// per-item result and scan bookkeeping
	always_ff @(posedge clk) begin
		if (start) begin
			status_q   <= ptb_pkg::ST_OK;
			assigned_q <= '0;
			elapsed_q  <= 1'b0;
			mask_q     <= '0;
			cnt_q      <= '0;
			case (q_entry.op)
				ptb_pkg::OP_REGISTER: begin
					if (table_full)
						status_q <= ptb_pkg::ST_FULL;
					else
						assigned_q <= ptb_pkg::IDX_W'(in_use_q);
				end
				ptb_pkg::OP_POLL: begin
					if (poll_bad)
						status_q <= ptb_pkg::ST_UNREG;
					else
						elapsed_q <= flags_q[pidx];
				end
				default: ;
			endcase
		end else if (state_q == ptb_pkg::S_SCAN) begin
			// slots past the eighth run without a mask bit
			if (fire)
				mask_q <= mask_q | (ptb_pkg::MASK_W'(1) << cnt_q);
			cnt_q <= cnt_q + TIDX_W'(1);
		end
		if (state_q == ptb_pkg::S_OUT && out_free) begin
			o_status_q   <= status_q;
			o_assigned_q <= assigned_q;
			o_elapsed_q  <= elapsed_q;
			o_mask_q     <= mask_q;
			o_ticks_q    <= ticks_q;
			o_seconds_q  <= seconds_q;
			o_rem_q      <= rem_q;
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.status            = o_status_q;
	assign out_ch.assigned_index    = o_assigned_q;
	assign out_ch.elapsed           = o_elapsed_q;
	assign out_ch.fire_mask         = o_mask_q;
	assign out_ch.tick_count        = o_ticks_q;
	assign out_ch.seconds_count     = o_seconds_q;
	assign out_ch.sub_second_micros = o_rem_q;
endmodule
`default_nettype wire

[hw/rtl/ptb_checker.sv]
`default_nettype none
module ptb_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [ptb_pkg::STAT_W-1:0]    status,
	input wire logic                          elapsed,
	input wire logic [ptb_pkg::MASK_W-1:0]    fire_mask,
	input wire logic [ptb_pkg::CNT32_W-1:0]   tick_count,
	input wire logic [ptb_pkg::MICRO_W-1:0]   sub_second_micros
);
	// a stalled result stays valid and keeps its tick count
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tick_count))
		else $error("result changed while stalled");

	a_micros_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sub_second_micros < ptb_pkg::MICROS_PER_SECOND)
		else $error("sub-second remainder out of range");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ptb_pkg::ST_OK |-> !elapsed && fire_mask == '0)
		else $error("error result carries flags");

	a_fire_not_poll: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fire_mask != '0 |-> !elapsed)
		else $error("tick result shows a poll flag");
endmodule

bind periodic_timer_bank_unit ptb_checker u_ptb_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_ch.valid),
	.out_ready         (out_ch.ready),
	.status            (out_ch.status),
	.elapsed           (out_ch.elapsed),
	.fire_mask         (out_ch.fire_mask),
	.tick_count        (out_ch.tick_count),
	.sub_second_micros (out_ch.sub_second_micros)
);
`default_nettype wire
